@@ rtl/mvna_pkg.sv @@
// Shared types, codes and fixed widths of the mesh vertex normal averager.
package mvna_pkg;

    localparam int VERTEX_SLOTS_DEF  = 1024;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int INDEX_W   = 10;
    localparam int COORD_W   = 32;
    localparam int COUNT_W   = 16;
    localparam int COUNT_MAX = 65535;
    localparam int ACT_W     = 2;
    localparam int IN_TW     = 136;

    localparam int MUL_W  = 32;
    localparam int ACC_W  = 64;
    localparam int ROOT_W = 32;
    localparam int DEN_W  = 32;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 2'd0,
        ACT_TRI   = 2'd1,
        ACT_READ  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        logic clear;
        logic issue;
        logic sub;
    } mac_ctl_t;

endpackage

@@ rtl/mvna_mac.sv @@
// Shared multiplier with registered product and add/subtract accumulator.
module mvna_mac import mvna_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  mac_ctl_t                ctl,
    input  logic signed [MUL_W-1:0] op_a,
    input  logic signed [MUL_W-1:0] op_b,
    output logic [ACC_W-1:0]        acc
);

    logic signed [2*MUL_W-1:0] prod_reg;
    logic                      pend_reg;
    logic                      sub_reg;
    logic [ACC_W-1:0]          acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
            sub_reg  <= 1'b0;
        end else begin
            pend_reg <= ctl.issue;
            sub_reg  <= ctl.sub;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.issue) begin
            prod_reg <= op_a * op_b;
        end
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (pend_reg) begin
            if (sub_reg) begin
                acc_reg <= acc_reg - ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule

@@ rtl/mvna_sqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
module mvna_sqrt import mvna_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [ACC_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [ACC_W-1:0] rem_reg;
    logic [ACC_W-1:0] root_reg;
    logic [ACC_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [ACC_W-1:0] trial;
    logic             ge;

    assign trial = root_reg + bit_reg;
    assign ge    = rem_reg >= trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && bit_reg[0]) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= radicand;
            root_reg <= '0;
            bit_reg  <= ACC_W'(1) << (ACC_W - 2);
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg  <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = root_reg[ROOT_W-1:0];

endmodule

@@ rtl/mvna_div.sv @@
// Iterative restoring divider, one quotient bit per cycle.
module mvna_div import mvna_pkg::*; #(
    parameter int QW = 34,
    parameter int SW = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DEN_W:0]   rem_init,
    input  logic [QW-1:0]    feed,
    input  logic [DEN_W-1:0] divisor,
    input  logic [SW-1:0]    steps,
    output logic             done,
    output logic [QW-1:0]    quot
);

    logic [DEN_W:0]   rem_reg;
    logic [QW-1:0]    feed_reg;
    logic [QW-1:0]    quot_reg;
    logic [DEN_W-1:0] div_reg;
    logic [SW-1:0]    left_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;
    logic [DEN_W:0]   r1;

    assign ge = rem_reg >= {1'b0, div_reg};
    assign r1 = ge ? rem_reg - {1'b0, div_reg} : rem_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            left_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                left_reg <= steps;
            end else if (busy_reg) begin
                left_reg <= left_reg - SW'(1);
                if (left_reg == SW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= rem_init;
            feed_reg <= feed;
            div_reg  <= divisor;
            quot_reg <= '0;
        end else if (busy_reg) begin
            quot_reg <= {quot_reg[QW-2:0], ge};
            rem_reg  <= {r1[DEN_W-1:0], feed_reg[QW-1]};
            feed_reg <= feed_reg << 1;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

@@ rtl/mesh_vertex_normal_averager.sv @@
// Top level: sequencer, vertex and accumulator memories, shared arithmetic units.
// One item at a time; s_tready is high only while idle.
// A triangle normalizes by shifting one bit per cycle; sqrt, divider and multiplier are shared.
// A read divides each sum by the use count in the bit-serial divider.
// After reset and after a clear item a pass over all VERTEX_SLOTS entries zeroes the sums.
module mesh_vertex_normal_averager import mvna_pkg::*; #(
    parameter int VERTEX_SLOTS  = VERTEX_SLOTS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int UNIT_W   = FRACTION_BITS + 2,
    localparam int OUT_BITS = 3 * UNIT_W + COUNT_W,
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [IN_TW-1:0]  s_tdata,
    // action
    input  logic [ACT_W-1:0]  s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    // normal_x, normal_y, normal_z, use_count, zero fill
    output logic [OUT_TW-1:0] m_tdata
);

    localparam int AW     = $clog2(VERTEX_SLOTS);
    localparam int IXW    = (AW > INDEX_W) ? AW : INDEX_W;
    localparam int SUM_W  = FRACTION_BITS + 18;
    localparam int MAG_W  = (2 * FRACTION_BITS + 2 > 33) ? 2 * FRACTION_BITS + 2 : 33;
    localparam int VEC_W  = MAG_W + 1;
    localparam int SW     = $clog2(SUM_W + 1);
    localparam int AMEM_W = 3 * SUM_W + COUNT_W;
    localparam int VMEM_W = 3 * COORD_W;

    typedef enum logic [15:0] {
        S_CLR     = 16'b0000000000000001,
        S_IDLE    = 16'b0000000000000010,
        S_FETCH   = 16'b0000000000000100,
        S_NPREP   = 16'b0000000000001000,
        S_NSHIFT  = 16'b0000000000010000,
        S_NSQ     = 16'b0000000000100000,
        S_NSQRT   = 16'b0000000001000000,
        S_NDIV    = 16'b0000000010000000,
        S_NEXT    = 16'b0000000100000000,
        S_CROSS   = 16'b0000001000000000,
        S_ACC_RD  = 16'b0000010000000000,
        S_ACC_UPD = 16'b0000100000000000,
        S_RD_REQ  = 16'b0001000000000000,
        S_RD_WAIT = 16'b0010000000000000,
        S_RD_DIV  = 16'b0100000000000000,
        S_OUT     = 16'b1000000000000000
    } state_t;

    function automatic logic [AW-1:0] addr_of(input logic [INDEX_W-1:0] idx);
        logic [IXW-1:0] ext;
        ext = IXW'(idx);
        return ext[AW-1:0];
    endfunction

    state_t state_reg;
    logic [2:0] cnt_reg;
    logic [1:0] comp_reg;
    logic [1:0] pass_reg;
    logic [1:0] corner_reg;
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] ia_reg, ib_reg, ic_reg, ri_reg;

    logic [VMEM_W-1:0] vmem [VERTEX_SLOTS];
    logic [VMEM_W-1:0] vrd_reg;
    logic [VMEM_W-1:0] pa_reg;
    logic [AMEM_W-1:0] amem [VERTEX_SLOTS];
    logic [AMEM_W-1:0] ard_reg;

    logic signed [VEC_W-1:0]  vec_reg [3];
    logic signed [VEC_W-1:0]  e2_reg [3];
    logic                     neg_reg [3];
    logic [MAG_W-1:0]         mag_reg [3];
    logic signed [UNIT_W-1:0] unit_reg [3];
    logic signed [UNIT_W-1:0] u1_reg [3];
    logic signed [UNIT_W-1:0] u2_reg [3];
    logic signed [UNIT_W-1:0] avg_reg [3];
    logic [COUNT_W-1:0]       rcnt_reg;
    logic [ROOT_W-1:0]        len_reg;
    logic                     m_valid_reg;
    logic [OUT_TW-1:0]        m_data_reg;

    action_t          act;
    logic [INDEX_W-1:0] in_vi, in_a, in_b, in_c;
    logic             vi_ok, tri_ok, s_xfer;

    logic             vwe;
    logic [AW-1:0]    vraddr;
    logic             awe;
    logic [AW-1:0]    awaddr, araddr, corner_addr;
    logic [AMEM_W-1:0] awdata;

    logic signed [SUM_W-1:0] a_sum [3];
    logic [COUNT_W-1:0]      a_cnt;
    logic signed [SUM_W-1:0] sel_sum;
    logic [SUM_W-1:0]        smag;
    logic [VEC_W-1:0]        vabs [3];
    logic [MAG_W-1:0]        any_mag;
    logic                    vec_zero;

    mac_ctl_t                mac_ctl;
    logic signed [MUL_W-1:0] op_a, op_b;
    logic [ACC_W-1:0]        acc;
    logic                    sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]       root;
    logic                    div_start, div_done;
    logic [DEN_W:0]          div_rem;
    logic [SUM_W-1:0]        div_feed;
    logic [DEN_W-1:0]        div_den;
    logic [SW-1:0]           div_steps;
    logic [SUM_W-1:0]        quot;
    logic [UNIT_W-1:0]       qv;
    logic                    q_neg;
    logic [UNIT_W-1:0]       q_signed;
    logic [1:0]              sq_sel;

    assign act    = action_t'(s_tuser);
    assign in_vi  = s_tdata[9:0];
    assign in_a   = s_tdata[115:106];
    assign in_b   = s_tdata[125:116];
    assign in_c   = s_tdata[135:126];
    assign vi_ok  = 32'(in_vi) < VERTEX_SLOTS;
    assign tri_ok = (32'(in_a) < VERTEX_SLOTS) && (32'(in_b) < VERTEX_SLOTS)
                    && (32'(in_c) < VERTEX_SLOTS);
    assign s_tready = (state_reg == S_IDLE);
    assign s_xfer   = s_tvalid && s_tready;

    assign vwe = s_xfer && (act == ACT_LOAD) && vi_ok;

    always_comb begin
        case (cnt_reg)
            3'd0:    vraddr = ia_reg;
            3'd1:    vraddr = ib_reg;
            default: vraddr = ic_reg;
        endcase
        case (corner_reg)
            2'd0:    corner_addr = ia_reg;
            2'd1:    corner_addr = ib_reg;
            default: corner_addr = ic_reg;
        endcase
    end

    assign araddr = (state_reg == S_ACC_RD) ? corner_addr : ri_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_sum[i] = ard_reg[i*SUM_W +: SUM_W];
            vabs[i]  = vec_reg[i][VEC_W-1] ? VEC_W'(-vec_reg[i]) : VEC_W'(vec_reg[i]);
        end
        a_cnt    = ard_reg[3*SUM_W +: COUNT_W];
        sel_sum  = a_sum[comp_reg];
        smag     = sel_sum[SUM_W-1] ? SUM_W'(-sel_sum) : SUM_W'(sel_sum);
        any_mag  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        vec_zero = (vec_reg[0] == '0) && (vec_reg[1] == '0) && (vec_reg[2] == '0);
    end

    always_comb begin
        awe    = 1'b0;
        awaddr = corner_addr;
        awdata = '0;
        case (state_reg)
            S_CLR: begin
                awe    = 1'b1;
                awaddr = clr_cnt_reg;
            end
            S_ACC_UPD: begin
                awe    = a_cnt != COUNT_W'(COUNT_MAX);
                awdata = {a_cnt + COUNT_W'(1),
                          a_sum[2] + SUM_W'(unit_reg[2]),
                          a_sum[1] + SUM_W'(unit_reg[1]),
                          a_sum[0] + SUM_W'(unit_reg[0])};
            end
            default: begin
                awe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (vwe) begin
            vmem[addr_of(in_vi)] <= s_tdata[105:10];
        end
        vrd_reg <= vmem[vraddr];
    end

    always_ff @(posedge aclk) begin
        if (awe) begin
            amem[awaddr] <= awdata;
        end
        ard_reg <= amem[araddr];
    end

    // shared multiplier operands
    always_comb begin
        mac_ctl = '0;
        op_a    = '0;
        op_b    = '0;
        sq_sel  = (cnt_reg < 3'd3) ? cnt_reg[1:0] : 2'd0;
        case (state_reg)
            S_NSQ: begin
                mac_ctl.issue = cnt_reg < 3'd3;
                mac_ctl.clear = cnt_reg == 3'd0;
                op_a = {1'b0, mag_reg[sq_sel][30:0]};
                op_b = {1'b0, mag_reg[sq_sel][30:0]};
            end
            S_CROSS: begin
                mac_ctl.issue = cnt_reg < 3'd2;
                mac_ctl.clear = cnt_reg == 3'd0;
                mac_ctl.sub   = cnt_reg == 3'd1;
                case (comp_reg)
                    2'd0: begin
                        op_a = (cnt_reg == 3'd0) ? MUL_W'(u1_reg[1]) : MUL_W'(u1_reg[2]);
                        op_b = (cnt_reg == 3'd0) ? MUL_W'(u2_reg[2]) : MUL_W'(u2_reg[1]);
                    end
                    2'd1: begin
                        op_a = (cnt_reg == 3'd0) ? MUL_W'(u1_reg[2]) : MUL_W'(u1_reg[0]);
                        op_b = (cnt_reg == 3'd0) ? MUL_W'(u2_reg[0]) : MUL_W'(u2_reg[2]);
                    end
                    default: begin
                        op_a = (cnt_reg == 3'd0) ? MUL_W'(u1_reg[0]) : MUL_W'(u1_reg[1]);
                        op_b = (cnt_reg == 3'd0) ? MUL_W'(u2_reg[1]) : MUL_W'(u2_reg[0]);
                    end
                endcase
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    assign sqrt_start = (state_reg == S_NSQ) && (cnt_reg == 3'd4);

    // shared divider operands
    always_comb begin
        div_start = ((state_reg == S_NDIV) || (state_reg == S_RD_DIV)) && (cnt_reg == 3'd0);
        if (state_reg == S_RD_DIV) begin
            div_rem   = (DEN_W + 1)'(smag[SUM_W-1]);
            div_feed  = {smag[SUM_W-2:0], 1'b0};
            div_den   = DEN_W'(a_cnt);
            div_steps = SW'(SUM_W);
            q_neg     = sel_sum[SUM_W-1];
        end else begin
            div_rem   = (DEN_W + 1)'(mag_reg[comp_reg][30:0]);
            div_feed  = '0;
            div_den   = len_reg;
            div_steps = SW'(FRACTION_BITS + 1);
            q_neg     = neg_reg[comp_reg];
        end
        qv       = {1'b0, quot[FRACTION_BITS:0]};
        q_signed = q_neg ? -qv : qv;
    end

    mvna_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .acc     (acc)
    );

    mvna_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc),
        .done     (sqrt_done),
        .root     (root)
    );

    mvna_div #(
        .QW (SUM_W),
        .SW (SW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .rem_init (div_rem),
        .feed     (div_feed),
        .divisor  (div_den),
        .steps    (div_steps),
        .done     (div_done),
        .quot     (quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            cnt_reg     <= '0;
            comp_reg    <= '0;
            pass_reg    <= '0;
            corner_reg  <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR: begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(VERTEX_SLOTS - 1)) begin
                        clr_cnt_reg <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_xfer) begin
                        case (act)
                            ACT_TRI: begin
                                if (tri_ok) begin
                                    ia_reg    <= addr_of(in_a);
                                    ib_reg    <= addr_of(in_b);
                                    ic_reg    <= addr_of(in_c);
                                    cnt_reg   <= '0;
                                    state_reg <= S_FETCH;
                                end
                            end
                            ACT_READ: begin
                                if (vi_ok) begin
                                    ri_reg    <= addr_of(in_vi);
                                    state_reg <= S_RD_REQ;
                                end else begin
                                    for (int i = 0; i < 3; i++) avg_reg[i] <= '0;
                                    rcnt_reg  <= '0;
                                    state_reg <= S_OUT;
                                end
                            end
                            ACT_CLEAR: begin
                                clr_cnt_reg <= '0;
                                state_reg   <= S_CLR;
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_FETCH: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    case (cnt_reg)
                        3'd1: begin
                            pa_reg <= vrd_reg;
                        end
                        3'd2: begin
                            for (int i = 0; i < 3; i++) begin
                                vec_reg[i] <= VEC_W'($signed(vrd_reg[i*COORD_W +: COORD_W]))
                                            - VEC_W'($signed(pa_reg[i*COORD_W +: COORD_W]));
                            end
                        end
                        3'd3: begin
                            for (int i = 0; i < 3; i++) begin
                                e2_reg[i] <= VEC_W'($signed(vrd_reg[i*COORD_W +: COORD_W]))
                                           - VEC_W'($signed(pa_reg[i*COORD_W +: COORD_W]));
                            end
                            pass_reg  <= '0;
                            state_reg <= S_NPREP;
                        end
                        default: begin
                            pa_reg <= pa_reg;
                        end
                    endcase
                end
                S_NPREP: begin
                    for (int i = 0; i < 3; i++) begin
                        neg_reg[i] <= vec_reg[i][VEC_W-1];
                        mag_reg[i] <= vabs[i][MAG_W-1:0];
                    end
                    if (vec_zero) begin
                        for (int i = 0; i < 3; i++) unit_reg[i] <= '0;
                        state_reg <= S_NEXT;
                    end else begin
                        state_reg <= S_NSHIFT;
                    end
                end
                S_NSHIFT: begin
                    if (any_mag[MAG_W-1:31] != '0) begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                    end else if (any_mag[MAG_W-1:30] == '0) begin
                        for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] << 1;
                    end else begin
                        cnt_reg   <= '0;
                        state_reg <= S_NSQ;
                    end
                end
                S_NSQ: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd4) begin
                        state_reg <= S_NSQRT;
                    end
                end
                S_NSQRT: begin
                    if (sqrt_done) begin
                        len_reg   <= root;
                        comp_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_NDIV;
                    end
                end
                S_NDIV: begin
                    if (cnt_reg == 3'd0) begin
                        cnt_reg <= 3'd1;
                    end else if (div_done) begin
                        unit_reg[comp_reg] <= q_signed;
                        cnt_reg <= '0;
                        if (comp_reg == 2'd2) begin
                            comp_reg  <= '0;
                            state_reg <= S_NEXT;
                        end else begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                end
                S_NEXT: begin
                    case (pass_reg)
                        2'd0: begin
                            for (int i = 0; i < 3; i++) begin
                                u1_reg[i]  <= unit_reg[i];
                                vec_reg[i] <= e2_reg[i];
                            end
                            pass_reg  <= 2'd1;
                            state_reg <= S_NPREP;
                        end
                        2'd1: begin
                            for (int i = 0; i < 3; i++) u2_reg[i] <= unit_reg[i];
                            comp_reg  <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_CROSS;
                        end
                        default: begin
                            corner_reg <= '0;
                            state_reg  <= S_ACC_RD;
                        end
                    endcase
                end
                S_CROSS: begin
                    cnt_reg <= cnt_reg + 3'd1;
                    if (cnt_reg == 3'd3) begin
                        vec_reg[comp_reg] <= acc[VEC_W-1:0];
                        cnt_reg <= '0;
                        if (comp_reg == 2'd2) begin
                            comp_reg  <= '0;
                            pass_reg  <= 2'd2;
                            state_reg <= S_NPREP;
                        end else begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                end
                S_ACC_RD: begin
                    state_reg <= S_ACC_UPD;
                end
                S_ACC_UPD: begin
                    if (corner_reg == 2'd2) begin
                        corner_reg <= '0;
                        state_reg  <= S_IDLE;
                    end else begin
                        corner_reg <= corner_reg + 2'd1;
                        state_reg  <= S_ACC_RD;
                    end
                end
                S_RD_REQ: begin
                    state_reg <= S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    rcnt_reg <= a_cnt;
                    if (a_cnt == '0) begin
                        for (int i = 0; i < 3; i++) avg_reg[i] <= '0;
                        state_reg <= S_OUT;
                    end else begin
                        comp_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_RD_DIV;
                    end
                end
                S_RD_DIV: begin
                    if (cnt_reg == 3'd0) begin
                        cnt_reg <= 3'd1;
                    end else if (div_done) begin
                        avg_reg[comp_reg] <= q_signed;
                        cnt_reg <= '0;
                        if (comp_reg == 2'd2) begin
                            comp_reg  <= '0;
                            state_reg <= S_OUT;
                        end else begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        m_data_reg  <= OUT_TW'({rcnt_reg, avg_reg[2], avg_reg[1], avg_reg[0]});
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ tb/tb.sv @@
// Testbench for the mesh vertex normal averager: self-checking random and directed run.
`timescale 1ns / 100ps

import mvna_pkg::*;

class normal_scoreboard;
    longint vx [1024];
    longint vy [1024];
    longint vz [1024];
    longint sum_x [1024];
    longint sum_y [1024];
    longint sum_z [1024];
    int unsigned uses [1024];
    logic [69:0] expected_q [$];
    int mismatches;

    function new();
        mismatches = 0;
        for (int i = 0; i < 1024; i++) begin
            vx[i] = 0; vy[i] = 0; vz[i] = 0;
            sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0; uses[i] = 0;
        end
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bit_w;
        root = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > n) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (n >= root + bit_w) begin
                n = n - (root + bit_w);
                root = (root >> 1) + bit_w;
            end else begin
                root = root >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return root;
    endfunction

    function void unit_vec(inout longint x, inout longint y, inout longint z);
        longint unsigned mx, my, mz, any, len, q;
        bit nx, ny, nz;
        nx = x < 0; ny = y < 0; nz = z < 0;
        mx = nx ? -x : x;
        my = ny ? -y : y;
        mz = nz ? -z : z;
        any = mx | my | mz;
        if (any == 0) return;
        while (any >= (64'd1 << 31)) begin
            mx = mx >> 1; my = my >> 1; mz = mz >> 1; any = any >> 1;
        end
        while (any < (64'd1 << 30)) begin
            mx = mx << 1; my = my << 1; mz = mz << 1; any = any << 1;
        end
        len = int_sqrt(mx * mx + my * my + mz * mz);
        q = (mx << 16) / len; x = nx ? -longint'(q) : longint'(q);
        q = (my << 16) / len; y = ny ? -longint'(q) : longint'(q);
        q = (mz << 16) / len; z = nz ? -longint'(q) : longint'(q);
    endfunction

    function void add_face(int idx, longint nx, longint ny, longint nz);
        if (uses[idx] >= COUNT_MAX) return;
        sum_x[idx] += nx; sum_y[idx] += ny; sum_z[idx] += nz;
        uses[idx] += 1;
    endfunction

    function longint mean(longint s, int unsigned cnt);
        longint unsigned mag;
        if (cnt == 0) return 0;
        mag = s < 0 ? -s : s;
        mag = mag / cnt;
        return s < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function void note_input(action_t act, logic [9:0] idx, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [9:0] a, logic [9:0] b, logic [9:0] c);
        longint e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic [17:0] ox, oy, oz;
        case (act)
            ACT_LOAD: begin
                vx[idx] = longint'($signed(cx));
                vy[idx] = longint'($signed(cy));
                vz[idx] = longint'($signed(cz));
            end
            ACT_TRI: begin
                e1x = vx[b] - vx[a]; e1y = vy[b] - vy[a]; e1z = vz[b] - vz[a];
                e2x = vx[c] - vx[a]; e2y = vy[c] - vy[a]; e2z = vz[c] - vz[a];
                unit_vec(e1x, e1y, e1z);
                unit_vec(e2x, e2y, e2z);
                nx = e1y * e2z - e1z * e2y;
                ny = e1z * e2x - e1x * e2z;
                nz = e1x * e2y - e1y * e2x;
                unit_vec(nx, ny, nz);
                add_face(a, nx, ny, nz);
                add_face(b, nx, ny, nz);
                add_face(c, nx, ny, nz);
            end
            ACT_READ: begin
                ox = 18'(mean(sum_x[idx], uses[idx]));
                oy = 18'(mean(sum_y[idx], uses[idx]));
                oz = 18'(mean(sum_z[idx], uses[idx]));
                expected_q.push_back({uses[idx][15:0], oz, oy, ox});
            end
            default: begin
                for (int i = 0; i < 1024; i++) begin
                    sum_x[i] = 0; sum_y[i] = 0; sum_z[i] = 0; uses[i] = 0;
                end
            end
        endcase
    endfunction

    function void check_result(logic [71:0] got);
        logic [69:0] exp_v;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        exp_v = expected_q.pop_front();
        if (got[69:0] !== exp_v || got[71:70] !== 2'b00) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp x=%h y=%h z=%h n=%0d, got x=%h y=%h z=%h n=%0d",
                         exp_v[17:0], exp_v[35:18], exp_v[53:36], exp_v[69:54],
                         got[17:0], got[35:18], got[53:36], got[69:54]);
        end
    endfunction
endclass

module tb;
    localparam int LIMIT = 6000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic [1:0]   s_tuser = ACT_LOAD;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    normal_scoreboard sb;
    int cycles = 0;
    int stall_left = 0;
    bit no_gaps = 0;
    int loaded [$];
    bit is_loaded [1024];

    mesh_vertex_normal_averager u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!no_gaps && $urandom_range(0, 99) < 25) begin
            stall_left <= pick_gap();
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send(action_t act, logic [9:0] idx, logic [31:0] cx, logic [31:0] cy,
                        logic [31:0] cz, logic [9:0] a, logic [9:0] b, logic [9:0] c);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {c, b, a, cz, cy, cx, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(act, idx, cx, cy, cz, a, b, c);
        if (act == ACT_LOAD && !is_loaded[idx]) begin
            is_loaded[idx] = 1;
            loaded.push_back(int'(idx));
        end
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic load(int idx, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
        send(ACT_LOAD, 10'(idx), cx, cy, cz, 10'($urandom), 10'($urandom), 10'($urandom));
    endtask

    task automatic tri_add(int a, int b, int c);
        send(ACT_TRI, 10'($urandom), $urandom, $urandom, $urandom, 10'(a), 10'(b), 10'(c));
    endtask

    task automatic read(int idx);
        send(ACT_READ, 10'(idx), $urandom, $urandom, $urandom,
             10'($urandom), 10'($urandom), 10'($urandom));
    endtask

    task automatic clear_all();
        send(ACT_CLEAR, 10'($urandom), $urandom, $urandom, $urandom,
             10'($urandom), 10'($urandom), 10'($urandom));
    endtask

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
        if (r < 7) return $urandom;
        if (r < 8) return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
        return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endfunction

    function automatic int pick_loaded();
        return loaded[$urandom_range(0, loaded.size() - 1)];
    endfunction

    initial begin
        int r, kind;
        sb = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        load(0, 32'h0, 32'h0, 32'h0);
        load(1023, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        load(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        load(2, 32'h0001_0000, 32'h0, 32'h0);
        load(3, 32'h0, 32'h0001_0000, 32'h0);
        load(4, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF);
        read(5);
        tri_add(0, 2, 3);
        tri_add(0, 1023, 1);
        tri_add(2, 2, 2);
        tri_add(0, 0, 4);
        tri_add(3, 2, 0);
        tri_add(1023, 4, 1);
        read(0);
        read(1023);
        read(2);
        read(4);
        clear_all();
        read(0);
        tri_add(0, 2, 3);
        read(3);
        read(1023);

        for (int n = 0; n < 1250; n++) begin
            if (n % 200 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (loaded.size() < 8 || r < 25) kind = 0;
            else if (r < 70) kind = 1;
            else if (r < 98) kind = 2;
            else kind = 3;
            case (kind)
                0: load(loaded.size() < 64 || $urandom_range(0, 3) == 0 ?
                        $urandom_range(0, 1023) : pick_loaded(),
                        rand_coord(), rand_coord(), rand_coord());
                1: tri_add(pick_loaded(), pick_loaded(), pick_loaded());
                2: read($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023) : pick_loaded());
                default: clear_all();
            endcase
        end
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (1500) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
